// ----- sv/assert_macros.svh -----
// Assertion macros for the checker file of the surface side evaluator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define SSE_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Clocked assertion that is also checked during reset.
`define SSE_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/sse_pkg.sv -----
// Types, widths and codes shared by the surface side evaluator modules.
`timescale 1ns / 1ps

package sse_pkg;

  // Datapath widths.
  localparam int LANES      = 3;
  localparam int OP_W       = 33;
  localparam int PROD_W     = 66;
  localparam int OFF_W      = 50;
  localparam int DIR_W      = 68;
  localparam int NUM_W      = 84;
  localparam int DV_W       = 32;
  localparam int DIV_BPS    = 3;
  localparam int DIV_STAGES = NUM_W / DIV_BPS;
  localparam int TERM_W     = 86;
  localparam int S_W        = 88;
  localparam int PP_W       = 65;
  localparam int PPH_W      = 56;
  localparam int LO_W       = 98;
  localparam int V_W        = 120;

  // Pipeline depth: four front stages, the divider, five back stages.
  localparam int FRONT_LAT = 4;
  localparam int BACK_LAT  = 5;
  localparam int LATENCY   = FRONT_LAT + DIV_STAGES + BACK_LAT;

  // The value one in Q32.32.
  localparam logic signed [63:0] ONE_Q32 = 64'sh0000_0001_0000_0000;

  typedef enum logic [3:0] {
    K_PLANE_X    = 4'd1,
    K_PLANE_Y    = 4'd2,
    K_PLANE_Z    = 4'd3,
    K_PLANE      = 4'd4,
    K_SPHERE     = 4'd5,
    K_CYLINDER   = 4'd6,
    K_ELL_CYL    = 4'd7,
    K_CONE       = 4'd8,
    K_ELLIPSOID  = 4'd9
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_KIND = 2'd1,
    ST_ZERO_DIV = 2'd2,
    ST_SAT      = 2'd3
  } status_t;

  // Control and sideband data that travel beside the divider lanes.
  typedef struct packed {
    logic                    valid;
    logic [3:0]              kind;
    status_t                 status;
    logic [LANES-1:0]        dneg;
    logic signed [31:0]      t;
    logic signed [DIR_W-1:0] direct;
  } side_t;

endpackage

// ----- sv/sse_front.sv -----
// Front stages: operand selection, squares and products, divider numerators.
`timescale 1ns / 1ps

module sse_front (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         in_valid,
  input  logic [3:0]                                   kind,
  input  logic signed [31:0]                           coef_a,
  input  logic signed [31:0]                           coef_b,
  input  logic signed [31:0]                           coef_c,
  input  logic signed [31:0]                           coef_d,
  input  logic signed [31:0]                           orient_scale,
  input  logic signed [31:0]                           px,
  input  logic signed [31:0]                           py,
  input  logic signed [31:0]                           pz,
  output sse_pkg::side_t                               side,
  output logic [sse_pkg::LANES-1:0][sse_pkg::NUM_W-1:0] num,
  output logic [sse_pkg::LANES-1:0][sse_pkg::DV_W-1:0]  dvm
);

  localparam int OP_W   = sse_pkg::OP_W;
  localparam int PROD_W = sse_pkg::PROD_W;
  localparam int OFF_W  = sse_pkg::OFF_W;
  localparam int DIR_W  = sse_pkg::DIR_W;
  localparam int NUM_W  = sse_pkg::NUM_W;
  localparam int DV_W   = sse_pkg::DV_W;
  localparam int LANES  = sse_pkg::LANES;

  // Magnitude of a signed 32-bit divisor; the most negative value maps to 2^31.
  function automatic logic [DV_W-1:0] mag32(input logic signed [31:0] v);
    logic signed [OP_W-1:0] w;
    w = OP_W'(v);
    return v[31] ? DV_W'(-w) : DV_W'(w);
  endfunction

  // Stage 0: input word.
  logic                v0;
  logic [3:0]          k0;
  logic signed [31:0]  a0, b0, c0, d0, t0, x0, y0, z0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= in_valid;
    end
    k0 <= kind;
    a0 <= coef_a;
    b0 <= coef_b;
    c0 <= coef_c;
    d0 <= coef_d;
    t0 <= orient_scale;
    x0 <= px;
    y0 <= py;
    z0 <= pz;
  end

  // Stage 1: differences and the multiplier operands for each form.
  logic signed [OP_W-1:0]  dxa, dya, dza, dyb, dzc;
  logic signed [OP_W-1:0]  opa_next [LANES];
  logic signed [OP_W-1:0]  opb_next [LANES];
  logic signed [OFF_W-1:0] off_next;
  logic signed [31:0]      dsel;
  sse_pkg::status_t        st_next;

  assign dxa = OP_W'(x0) - OP_W'(a0);
  assign dya = OP_W'(y0) - OP_W'(a0);
  assign dza = OP_W'(z0) - OP_W'(a0);
  assign dyb = OP_W'(y0) - OP_W'(b0);
  assign dzc = OP_W'(z0) - OP_W'(c0);

  always_comb begin
    opa_next[0] = OP_W'(x0);
    opb_next[0] = OP_W'(x0);
    opa_next[1] = OP_W'(y0);
    opb_next[1] = OP_W'(y0);
    opa_next[2] = OP_W'(z0);
    opb_next[2] = OP_W'(z0);
    off_next    = '0;
    dsel        = a0;
    st_next     = sse_pkg::ST_OK;
    case (k0)
      sse_pkg::K_PLANE_X: begin
        off_next = OFF_W'(dxa) <<< 16;
      end
      sse_pkg::K_PLANE_Y: begin
        off_next = OFF_W'(dya) <<< 16;
      end
      sse_pkg::K_PLANE_Z: begin
        off_next = OFF_W'(dza) <<< 16;
      end
      sse_pkg::K_PLANE: begin
        opa_next[0] = OP_W'(a0);
        opa_next[1] = OP_W'(b0);
        opa_next[2] = OP_W'(c0);
        off_next    = -(OFF_W'(d0) <<< 16);
      end
      sse_pkg::K_SPHERE: begin
        opa_next[0] = dxa;
        opb_next[0] = dxa;
        opa_next[1] = dyb;
        opb_next[1] = dyb;
        opa_next[2] = dzc;
        opb_next[2] = dzc;
        off_next    = -OFF_W'(sse_pkg::ONE_Q32);
        dsel        = d0;
        if (d0 == '0) begin
          st_next = sse_pkg::ST_ZERO_DIV;
        end
      end
      sse_pkg::K_CYLINDER: begin
        off_next = -(OFF_W'(a0) <<< 16);
      end
      sse_pkg::K_ELL_CYL: begin
        off_next = -OFF_W'(sse_pkg::ONE_Q32);
        if (a0 == '0 || b0 == '0) begin
          st_next = sse_pkg::ST_ZERO_DIV;
        end
      end
      sse_pkg::K_CONE: begin
        opa_next[2] = dza;
        opb_next[2] = dza;
        if (b0 == '0) begin
          st_next = sse_pkg::ST_ZERO_DIV;
        end
      end
      sse_pkg::K_ELLIPSOID: begin
        off_next = -OFF_W'(sse_pkg::ONE_Q32);
        if (a0 == '0 || b0 == '0 || c0 == '0) begin
          st_next = sse_pkg::ST_ZERO_DIV;
        end
      end
      default: begin
        st_next = sse_pkg::ST_BAD_KIND;
      end
    endcase
  end

  logic                    v1;
  logic [3:0]              k1;
  sse_pkg::status_t        st1;
  logic signed [31:0]      t1;
  logic signed [OFF_W-1:0] off1;
  logic [LANES-1:0]        dneg1;
  logic [DV_W-1:0]         dv1 [LANES];
  logic signed [OP_W-1:0]  opa [LANES];
  logic signed [OP_W-1:0]  opb [LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    k1     <= k0;
    st1    <= st_next;
    t1     <= t0;
    off1   <= off_next;
    dneg1  <= {c0[31], b0[31], dsel[31]};
    dv1[0] <= mag32(dsel);
    dv1[1] <= mag32(b0);
    dv1[2] <= mag32(c0);
    for (int i = 0; i < LANES; i++) begin
      opa[i] <= opa_next[i];
      opb[i] <= opb_next[i];
    end
  end

  // Stage 2: one 33 by 33 multiply per lane.
  logic                     v2;
  logic [3:0]               k2;
  sse_pkg::status_t         st2;
  logic signed [31:0]       t2;
  logic signed [OFF_W-1:0]  off2;
  logic [LANES-1:0]         dneg2;
  logic [DV_W-1:0]          dv2 [LANES];
  logic signed [PROD_W-1:0] prod [LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    k2    <= k1;
    st2   <= st1;
    t2    <= t1;
    off2  <= off1;
    dneg2 <= dneg1;
    for (int i = 0; i < LANES; i++) begin
      dv2[i]  <= dv1[i];
      prod[i] <= opa[i] * opb[i];
    end
  end

  // Stage 3: divider numerators and the part of the form that needs no division.
  logic signed [DIR_W-1:0]  sum3, sum2, dir_next;
  logic [PROD_W-1:0]        n_next [LANES];

  assign sum3 = DIR_W'(prod[0]) + DIR_W'(prod[1]) + DIR_W'(prod[2]);
  assign sum2 = DIR_W'(prod[0]) + DIR_W'(prod[1]);

  always_comb begin
    n_next[0] = prod[0];
    n_next[1] = prod[1];
    n_next[2] = prod[2];
    dir_next  = DIR_W'(off2);
    case (k2)
      sse_pkg::K_PLANE: begin
        dir_next = sum3 + DIR_W'(off2);
      end
      sse_pkg::K_SPHERE: begin
        n_next[0] = sum3[PROD_W-1:0];
      end
      sse_pkg::K_CYLINDER: begin
        dir_next = sum2 + DIR_W'(off2);
      end
      sse_pkg::K_CONE: begin
        n_next[1] = prod[2];
        dir_next  = sum2 + DIR_W'(off2);
      end
      default: begin
        dir_next = DIR_W'(off2);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side.valid <= 1'b0;
    end else begin
      side.valid <= v2;
    end
    side.kind   <= k2;
    side.status <= st2;
    side.dneg   <= dneg2;
    side.t      <= t2;
    side.direct <= dir_next;
    for (int i = 0; i < LANES; i++) begin
      num[i] <= {{(NUM_W - PROD_W - 16){1'b0}}, n_next[i], 16'h0000};
      dvm[i] <= dv2[i];
    end
  end

endmodule

// ----- sv/sse_div.sv -----
// Pipelined unsigned restoring divider, DIV_BPS quotient bits per stage.
`timescale 1ns / 1ps

module sse_div (
  input  logic                      clk,
  input  logic [sse_pkg::NUM_W-1:0] num_in,
  input  logic [sse_pkg::DV_W-1:0]  dv_in,
  output logic [sse_pkg::NUM_W-1:0] quot
);

  localparam int NUM_W  = sse_pkg::NUM_W;
  localparam int DV_W   = sse_pkg::DV_W;
  localparam int BPS    = sse_pkg::DIV_BPS;
  localparam int STAGES = sse_pkg::DIV_STAGES;

  // BPS restoring steps: the dividend shifts out at the top of work while
  // the quotient bits shift in at the bottom.
  function automatic logic [DV_W+NUM_W-1:0] div_step(
    input logic [DV_W-1:0]  rem_in,
    input logic [NUM_W-1:0] work_in,
    input logic [DV_W-1:0]  dv
  );
    logic [DV_W:0]    trial;
    logic [DV_W-1:0]  r;
    logic [NUM_W-1:0] w;
    r = rem_in;
    w = work_in;
    for (int i = 0; i < BPS; i++) begin
      trial = {r, w[NUM_W-1]} - {1'b0, dv};
      if (!trial[DV_W]) begin
        r = trial[DV_W-1:0];
        w = {w[NUM_W-2:0], 1'b1};
      end else begin
        r = {r[DV_W-2:0], w[NUM_W-1]};
        w = {w[NUM_W-2:0], 1'b0};
      end
    end
    return {r, w};
  endfunction

  logic [DV_W-1:0]  rem  [STAGES];
  logic [NUM_W-1:0] work [STAGES];
  logic [DV_W-1:0]  dvr  [STAGES];

  // One register stage per group of quotient bits.
  always_ff @(posedge clk) begin
    {rem[0], work[0]} <= div_step('0, num_in, dv_in);
    dvr[0]            <= dv_in;
    for (int k = 1; k < STAGES; k++) begin
      {rem[k], work[k]} <= div_step(rem[k-1], work[k-1], dvr[k-1]);
      dvr[k]            <= dvr[k-1];
    end
  end

  assign quot = work[STAGES-1];

endmodule

// ----- sv/sse_back.sv -----
// Back stages: signed quotient terms, sum, orientation multiply and saturation.
`timescale 1ns / 1ps

module sse_back (
  input  logic                                         clk,
  input  logic                                         rst,
  input  sse_pkg::side_t                               side_in,
  input  logic [sse_pkg::LANES-1:0][sse_pkg::NUM_W-1:0] quot,
  output logic                                         done,
  output logic signed [63:0]                           side_value,
  output logic [1:0]                                   status
);

  localparam int LANES  = sse_pkg::LANES;
  localparam int TERM_W = sse_pkg::TERM_W;
  localparam int S_W    = sse_pkg::S_W;
  localparam int PP_W   = sse_pkg::PP_W;
  localparam int PPH_W  = sse_pkg::PPH_W;
  localparam int LO_W   = sse_pkg::LO_W;
  localparam int V_W    = sse_pkg::V_W;
  localparam int SH_W   = V_W - 16;

  // Stage A: pick the quotients a form uses and give each its sign.
  logic [LANES-1:0]         use_q, sub_q;
  logic signed [TERM_W-1:0] term_next [LANES];

  always_comb begin
    use_q = '0;
    sub_q = '0;
    case (side_in.kind)
      sse_pkg::K_SPHERE:    use_q = 3'b001;
      sse_pkg::K_ELL_CYL:   use_q = 3'b011;
      sse_pkg::K_CONE: begin
        use_q = 3'b010;
        sub_q = 3'b010;
      end
      sse_pkg::K_ELLIPSOID: use_q = 3'b111;
      default:              use_q = '0;
    endcase
    for (int i = 0; i < LANES; i++) begin
      if (!use_q[i]) begin
        term_next[i] = '0;
      end else if (side_in.dneg[i] ^ sub_q[i]) begin
        term_next[i] = -$signed(TERM_W'(quot[i]));
      end else begin
        term_next[i] = $signed(TERM_W'(quot[i]));
      end
    end
  end

  sse_pkg::side_t           side_a;
  logic signed [TERM_W-1:0] term [LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      side_a.valid <= 1'b0;
    end else begin
      side_a.valid <= side_in.valid;
    end
    side_a.kind   <= side_in.kind;
    side_a.status <= side_in.status;
    side_a.dneg   <= side_in.dneg;
    side_a.t      <= side_in.t;
    side_a.direct <= side_in.direct;
    for (int i = 0; i < LANES; i++) begin
      term[i] <= term_next[i];
    end
  end

  // Stage B: the surface value in Q32.32.
  logic                   v_b;
  sse_pkg::status_t       st_b;
  logic signed [31:0]     t_b;
  logic signed [S_W-1:0]  s_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_b <= 1'b0;
    end else begin
      v_b <= side_a.valid;
    end
    st_b <= side_a.status;
    t_b  <= side_a.t;
    s_b  <= S_W'(side_a.direct) + S_W'(term[0]) + S_W'(term[1]) + S_W'(term[2]);
  end

  // Stage C: partial products of the value and the orientation scale.
  logic                    v_c;
  sse_pkg::status_t        st_c;
  logic signed [PP_W-1:0]  pp0, pp1;
  logic signed [PPH_W-1:0] pp2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_c <= 1'b0;
    end else begin
      v_c <= v_b;
    end
    st_c <= st_b;
    pp0  <= $signed({1'b0, s_b[31:0]}) * t_b;
    pp1  <= $signed({1'b0, s_b[63:32]}) * t_b;
    pp2  <= $signed(s_b[S_W-1:64]) * t_b;
  end

  // Stage D: combine the two low partial products.
  logic                    v_d;
  sse_pkg::status_t        st_d;
  logic signed [LO_W-1:0]  lo_d;
  logic signed [PPH_W-1:0] pp2_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_d <= 1'b0;
    end else begin
      v_d <= v_c;
    end
    st_d  <= st_c;
    lo_d  <= LO_W'(pp0) + (LO_W'(pp1) <<< 32);
    pp2_d <= pp2;
  end

  // Stage E: full product, shift to Q32.32 and clamp to 64 bits.
  logic signed [V_W-1:0] v_full;
  logic [SH_W-1:0]       sh;
  logic                  fits;
  logic signed [63:0]    val_next;
  sse_pkg::status_t      st_next;

  assign v_full = V_W'(lo_d) + (V_W'(pp2_d) <<< 64);
  assign sh     = v_full[V_W-1:16];
  assign fits   = (&sh[SH_W-1:63]) || !(|sh[SH_W-1:63]);

  always_comb begin
    if (st_d != sse_pkg::ST_OK) begin
      val_next = '0;
      st_next  = st_d;
    end else if (fits) begin
      val_next = $signed(sh[63:0]);
      st_next  = sse_pkg::ST_OK;
    end else begin
      val_next = v_full[V_W-1] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
      st_next  = sse_pkg::ST_SAT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v_d;
    end
    side_value <= val_next;
    status     <= st_next;
  end

endmodule

// ----- sv/surface_side_evaluator.sv -----
// Top level of the surface side evaluator pipeline.
// Usage:
//   An input word (kind, coef_a..coef_d, orient_scale, px, py, pz) is taken
//   at a rising edge where start is high and busy is low. busy is high only
//   during reset and the cycle after it, so a new word can enter every cycle.
//   The result word (side_value, status) shows on its ports for exactly one
//   cycle with done high, in the order the words came in. The receiver has
//   no way to stall the block.
//   Throughput is one word per cycle; the 37 register stages are four front
//   stages (input, operand select, multiply, numerator), 28 divider stages of
//   three quotient bits each and five back stages (sign, sum, partial
//   products, combine, clamp). Three divider lanes run side by side.
//   status: 0 ok, 1 unknown surface kind, 2 zero divisor, 3 saturated.
//   A synchronous reset drops every word in flight; nothing is delivered for
//   them.
`timescale 1ns / 1ps

module surface_side_evaluator (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         kind,
  input  logic signed [31:0] coef_a,
  input  logic signed [31:0] coef_b,
  input  logic signed [31:0] coef_c,
  input  logic signed [31:0] coef_d,
  input  logic signed [31:0] orient_scale,
  input  logic signed [31:0] px,
  input  logic signed [31:0] py,
  input  logic signed [31:0] pz,
  output logic               done,
  output logic signed [63:0] side_value,
  output logic [1:0]         status
);

  localparam int LANES  = sse_pkg::LANES;
  localparam int STAGES = sse_pkg::DIV_STAGES;

  // Hold off input words while reset is in progress.
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  sse_pkg::side_t                                side_f;
  logic [LANES-1:0][sse_pkg::NUM_W-1:0]          num;
  logic [LANES-1:0][sse_pkg::DV_W-1:0]           dvm;
  logic [LANES-1:0][sse_pkg::NUM_W-1:0]          quot;

  sse_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (start & ~busy),
    .kind         (kind),
    .coef_a       (coef_a),
    .coef_b       (coef_b),
    .coef_c       (coef_c),
    .coef_d       (coef_d),
    .orient_scale (orient_scale),
    .px           (px),
    .py           (py),
    .pz           (pz),
    .side         (side_f),
    .num          (num),
    .dvm          (dvm)
  );

  // Three divider lanes.
  for (genvar g = 0; g < LANES; g++) begin : g_div
    sse_div u_div (
      .clk    (clk),
      .num_in (num[g]),
      .dv_in  (dvm[g]),
      .quot   (quot[g])
    );
  end

  // Sideband delay line matched to the divider depth.
  sse_pkg::side_t side_dl [STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < STAGES; k++) begin
        side_dl[k].valid <= 1'b0;
      end
    end else begin
      side_dl[0] <= side_f;
      for (int k = 1; k < STAGES; k++) begin
        side_dl[k] <= side_dl[k-1];
      end
    end
  end

  sse_back u_back (
    .clk        (clk),
    .rst        (rst),
    .side_in    (side_dl[STAGES-1]),
    .quot       (quot),
    .done       (done),
    .side_value (side_value),
    .status     (status)
  );

endmodule

// ----- sv/sse_checker.sv -----
// Port-level assertions for the surface side evaluator, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sse_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic [3:0]         kind,
  input logic               done,
  input logic signed [63:0] side_value,
  input logic [1:0]         status
);

  localparam int LAT = sse_pkg::LATENCY;

  // Reset keeps the input side closed.
  `SSE_ASSERT_ALWAYS(a_busy_in_reset, clk, rst |=> busy, "busy low after reset cycle")

  // Every result goes back to an input word that the pipeline took earlier.
  `SSE_ASSERT(a_done_latency, clk, rst, done |-> $past(start && !busy, LAT), "result without a matching input word")

  // An unknown kind gives status 1 and a zero value.
  `SSE_ASSERT(a_bad_kind, clk, rst, (done && $past(start && !busy && (kind == 4'd0 || kind > sse_pkg::K_ELLIPSOID), LAT)) |-> (status == sse_pkg::ST_BAD_KIND && side_value == 64'sd0), "unknown kind not flagged")

  // Error results carry a zero value.
  `SSE_ASSERT(a_err_zero, clk, rst, (done && (status == sse_pkg::ST_BAD_KIND || status == sse_pkg::ST_ZERO_DIV)) |-> side_value == 64'sd0, "error result with nonzero value")

endmodule

bind surface_side_evaluator sse_checker u_sse_checker (.*);
